FILE: rtl/core/dcsw_pkg.sv
// Package for the daisy-chain segment writer: state and code types, the
// frame control structs and the character-to-segment lookup.
// Used by every other file of the block; depends on nothing.
package dcsw_pkg;

   // Field widths fixed by the item layout.
   localparam int unsigned TYPE_W  = 2;
   localparam int unsigned DEV_W   = 3;
   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned FRAME_W = 16;
   localparam int unsigned CSR_W   = 2;

   // Request type codes.
   typedef enum logic [TYPE_W-1:0] {
      REQ_RAW   = 2'd0,
      REQ_DIGIT = 2'd1,
      REQ_CHAR  = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   // Configuration register indexes.
   localparam logic [CSR_W-1:0] CSR_DECODE_ON   = 2'd0;
   localparam logic [CSR_W-1:0] CSR_DECODE_ADDR = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [BYTE_W-1:0] DECODE_ON_RESET   = 8'hFF;
   localparam logic [BYTE_W-1:0] DECODE_ADDR_RESET = 8'h09;
   localparam logic [BYTE_W-1:0] DECODE_OFF_DATA   = 8'h00;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BCAST,
      ST_FINAL
   } state_type;

   // What the frame unit needs to build one frame of a transaction.
   typedef struct packed {
      logic [DEV_W-1:0]  slot;
      logic [DEV_W-1:0]  dev;
      logic [BYTE_W-1:0] addr;
      logic [BYTE_W-1:0] data;
   } frame_ctl_type;

   // What the frame unit returns.
   typedef struct packed {
      logic [FRAME_W-1:0] frame;
      logic               eot;
   } frame_res_type;

   // Result of a character lookup.
   typedef struct packed {
      logic              hit;
      logic [BYTE_W-1:0] pat;
   } glyph_type;

   localparam logic [BYTE_W-1:0] DIGIT_TAB [0:9] = '{
      8'h7e, 8'h30, 8'h6d, 8'h79, 8'h33, 8'h5b, 8'h5f, 8'h70, 8'h7f, 8'h7b
   };

   // Letters and symbols from code 65 up to code 117.
   localparam logic [BYTE_W-1:0] GLYPH_FIRST = 8'd65;
   localparam logic [BYTE_W-1:0] GLYPH_LAST  = 8'd117;
   localparam logic [BYTE_W-1:0] GLYPH_TAB [0:52] = '{
      8'h77, 8'h00, 8'h4e, 8'h00, 8'h4f, 8'h47, 8'h00, 8'h37, 8'h00, 8'h00,
      8'h00, 8'h0e, 8'h00, 8'h00, 8'h00, 8'h67, 8'h73, 8'h00, 8'h00, 8'h00,
      8'h3e, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h08, 8'h00, 8'h00, 8'h1f, 8'h0d, 8'h3d, 8'h00, 8'h00, 8'h00, 8'h17,
      8'h00, 8'h00, 8'h00, 8'h06, 8'h00, 8'h15, 8'h1d, 8'h00, 8'h00, 8'h05,
      8'h00, 8'h00, 8'h1c
   };

   localparam logic [BYTE_W-1:0] CHR_MINUS  = 8'd45;
   localparam logic [BYTE_W-1:0] CHR_SPACE  = 8'd32;
   localparam logic [BYTE_W-1:0] CHR_EQUALS = 8'd61;
   localparam logic [BYTE_W-1:0] CHR_POINT  = 8'd46;
   localparam logic [BYTE_W-1:0] SEG_MINUS  = 8'h01;
   localparam logic [BYTE_W-1:0] SEG_SPACE  = 8'h00;
   localparam logic [BYTE_W-1:0] SEG_EQUALS = 8'h09;
   localparam logic [BYTE_W-1:0] SEG_POINT  = 8'h80;

   // Map a character code to its segment pattern; hit is low when the
   // character has no pattern at all.
   function automatic glyph_type glyph_lookup(input logic [BYTE_W-1:0] c);
      glyph_type        g;
      logic [BYTE_W-1:0] off;
      off   = c - GLYPH_FIRST;
      g.hit = 1'b1;
      g.pat = '0;
      if (c <= 8'd9) begin
         g.pat = DIGIT_TAB[c[3:0]];
      end else if (c >= GLYPH_FIRST && c <= GLYPH_LAST) begin
         g.pat = GLYPH_TAB[off[5:0]];
      end else if (c == CHR_MINUS) begin
         g.pat = SEG_MINUS;
      end else if (c == CHR_SPACE) begin
         g.pat = SEG_SPACE;
      end else if (c == CHR_EQUALS) begin
         g.pat = SEG_EQUALS;
      end else if (c == CHR_POINT) begin
         g.pat = SEG_POINT;
      end else begin
         g.hit = 1'b0;
      end
      return g;
   endfunction

endpackage

FILE: rtl/core/dcsw_if.sv
// Channel interfaces of the daisy-chain segment writer: request and frame.
// Depends on dcsw_pkg for the field widths.
interface dcsw_req_if;
   logic                         valid;
   logic                         ready;
   logic [dcsw_pkg::TYPE_W-1:0]  req_type;
   logic [dcsw_pkg::DEV_W-1:0]   device;
   logic [dcsw_pkg::BYTE_W-1:0]  reg_addr;
   logic [dcsw_pkg::BYTE_W-1:0]  value;
   logic                         dot;

   modport source (output valid, req_type, device, reg_addr, value, dot,
                   input ready);
   modport sink   (input valid, req_type, device, reg_addr, value, dot,
                   output ready);
endinterface

interface dcsw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dcsw_pkg::FRAME_W-1:0]  frame;
   logic                          end_of_transaction;
   logic                          last;

   modport source (output valid, frame, end_of_transaction, last,
                   input ready);
   modport sink   (input valid, frame, end_of_transaction, last,
                   output ready);
endinterface

FILE: rtl/core/daisy_chain_segment_writer.sv
// Daisy-chain segment writer. One frame per cycle while the sink takes them.
// A raw write gives CHAIN_LENGTH frames; a decode-mode write gives
// (CHAIN_LENGTH+1)*CHAIN_LENGTH, or CHAIN_LENGTH*CHAIN_LENGTH for an unmapped
// character. A taken item is registered into the sequencer state, and each of
// its frames goes through the output register. Items are taken only in idle.
// Synchronous reset clears control and restores the configuration registers.
module daisy_chain_segment_writer #(
   parameter int unsigned CHAIN_LENGTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   dcsw_req_if.sink                     req,
   dcsw_rsp_if.source                   rsp,
   input  logic                         csr_we,
   input  logic [dcsw_pkg::CSR_W-1:0]   csr_index,
   input  logic [dcsw_pkg::BYTE_W-1:0]  csr_wdata
);

   localparam logic [dcsw_pkg::DEV_W-1:0] CHAIN_W = dcsw_pkg::DEV_W'(CHAIN_LENGTH);
   localparam logic [dcsw_pkg::DEV_W-1:0] LAST_SLOT = CHAIN_W - 3'd1;

   dcsw_pkg::state_type          state_ff, state_in;
   logic [dcsw_pkg::DEV_W-1:0]   slot_ff, slot_in;
   logic [dcsw_pkg::DEV_W-1:0]   bdev_ff, bdev_in;
   logic                         has_final_ff, has_final_in;
   logic [dcsw_pkg::DEV_W-1:0]   dev_ff, dev_in;
   logic [dcsw_pkg::BYTE_W-1:0]  addr_ff, addr_in;
   logic [dcsw_pkg::BYTE_W-1:0]  data_ff, data_in;
   logic [dcsw_pkg::BYTE_W-1:0]  bdata_ff, bdata_in;
   logic [dcsw_pkg::BYTE_W-1:0]  decode_on_ff;
   logic [dcsw_pkg::BYTE_W-1:0]  decode_addr_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [dcsw_pkg::FRAME_W-1:0] rsp_frame_ff, rsp_frame_in;
   logic                         rsp_eot_ff, rsp_eot_in;
   logic                         rsp_last_ff, rsp_last_in;

   dcsw_pkg::frame_ctl_type      fctl;
   dcsw_pkg::frame_res_type      fres;
   dcsw_pkg::glyph_type          glyph;
   dcsw_pkg::req_code_type       code;
   logic                         accept;
   logic                         dev_ok;
   logic                         emit;
   logic                         last_frame;
   logic [dcsw_pkg::BYTE_W-1:0]  dot_byte;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         decode_on_ff   <= dcsw_pkg::DECODE_ON_RESET;
         decode_addr_ff <= dcsw_pkg::DECODE_ADDR_RESET;
      end else if (csr_we) begin
         if (csr_index == dcsw_pkg::CSR_DECODE_ON) begin
            decode_on_ff <= csr_wdata;
         end
         if (csr_index == dcsw_pkg::CSR_DECODE_ADDR) begin
            decode_addr_ff <= csr_wdata;
         end
      end
   end

   // The frame unit is shared by the broadcast and the addressed transaction.
   always_comb begin
      fctl.slot = slot_ff;
      fctl.dev  = (state_ff == dcsw_pkg::ST_BCAST) ? bdev_ff : dev_ff;
      fctl.addr = (state_ff == dcsw_pkg::ST_BCAST) ? decode_addr_ff : addr_ff;
      fctl.data = (state_ff == dcsw_pkg::ST_BCAST) ? bdata_ff : data_ff;
   end

   dcsw_frame_unit #(
      .CHAIN_LENGTH (CHAIN_LENGTH)
   ) u_frame (
      .ctl (fctl),
      .res (fres)
   );

   // Request decode: device range, character lookup and decimal point.
   always_comb begin
      code     = dcsw_pkg::req_code_type'(req.req_type);
      dev_ok   = (req.device != '0) && (req.device <= CHAIN_W);
      glyph    = dcsw_pkg::glyph_lookup(req.value);
      dot_byte = {req.dot, 7'b0};
      accept   = req.valid && req.ready;
   end

   assign req.ready = (state_ff == dcsw_pkg::ST_IDLE);

   // Sequencer: next state, counters and the output register load.
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      bdev_in      = bdev_ff;
      has_final_in = has_final_ff;
      dev_in       = dev_ff;
      addr_in      = addr_ff;
      data_in      = data_ff;
      bdata_in     = bdata_ff;
      emit         = 1'b0;
      last_frame   = 1'b0;

      unique case (state_ff)
         dcsw_pkg::ST_IDLE: begin
            dev_in  = req.device;
            addr_in = req.reg_addr;
            slot_in = '0;
            bdev_in = 3'd1;
            if (accept && dev_ok) begin
               unique case (code)
                  dcsw_pkg::REQ_RAW: begin
                     data_in      = req.value;
                     has_final_in = 1'b1;
                     state_in     = dcsw_pkg::ST_FINAL;
                  end
                  dcsw_pkg::REQ_DIGIT: begin
                     data_in      = req.value | dot_byte;
                     bdata_in     = decode_on_ff;
                     has_final_in = 1'b1;
                     state_in     = dcsw_pkg::ST_BCAST;
                  end
                  dcsw_pkg::REQ_CHAR: begin
                     data_in      = glyph.pat | dot_byte;
                     bdata_in     = dcsw_pkg::DECODE_OFF_DATA;
                     has_final_in = glyph.hit;
                     state_in     = dcsw_pkg::ST_BCAST;
                  end
                  default: begin
                     state_in = dcsw_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         dcsw_pkg::ST_BCAST: begin
            emit       = !rsp_valid_ff || rsp.ready;
            last_frame = fres.eot && (bdev_ff == CHAIN_W) && !has_final_ff;
            if (emit) begin
               slot_in = fres.eot ? '0 : slot_ff + 3'd1;
               if (fres.eot) begin
                  bdev_in = bdev_ff + 3'd1;
                  if (bdev_ff == CHAIN_W) begin
                     state_in = has_final_ff ? dcsw_pkg::ST_FINAL : dcsw_pkg::ST_IDLE;
                  end
               end
            end
         end
         dcsw_pkg::ST_FINAL: begin
            emit       = !rsp_valid_ff || rsp.ready;
            last_frame = fres.eot;
            if (emit) begin
               slot_in = fres.eot ? '0 : slot_ff + 3'd1;
               if (fres.eot) begin
                  state_in = dcsw_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = dcsw_pkg::ST_IDLE;
         end
      endcase

      // Output register: loads a frame when empty or being taken.
      rsp_valid_in = emit ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);
      rsp_frame_in = emit ? fres.frame : rsp_frame_ff;
      rsp_eot_in   = emit ? fres.eot : rsp_eot_ff;
      rsp_last_in  = emit ? last_frame : rsp_last_ff;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dcsw_pkg::ST_IDLE;
         slot_ff      <= '0;
         bdev_ff      <= 3'd1;
         has_final_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         bdev_ff      <= bdev_in;
         has_final_ff <= has_final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      dev_ff       <= dev_in;
      addr_ff      <= addr_in;
      data_ff      <= data_in;
      bdata_ff     <= bdata_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_eot_ff   <= rsp_eot_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.frame              = rsp_frame_ff;
   assign rsp.end_of_transaction = rsp_eot_ff;
   assign rsp.last               = rsp_last_ff;

`ifndef SYNTHESIS
   // The final frame of an item always closes a transaction.
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.last |-> rsp.end_of_transaction)
      else $error("last frame without end of transaction");

   // The slot counter stays inside the chain.
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= LAST_SLOT)
      else $error("slot counter beyond chain");

   // Broadcast device stays between one and the chain length.
   a_bdev_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == dcsw_pkg::ST_BCAST |-> bdev_ff != '0 && bdev_ff <= CHAIN_W)
      else $error("broadcast device out of range");

   // Loading the last frame returns the sequencer to idle.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      emit && last_frame |=> state_ff == dcsw_pkg::ST_IDLE)
      else $error("sequencer busy after last frame");
`endif

endmodule

FILE: rtl/core/dcsw_frame_unit.sv
// Frame unit: builds one frame of a transaction from the slot position.
// Depends on dcsw_pkg for the control and result structs.
module dcsw_frame_unit #(
   parameter int unsigned CHAIN_LENGTH = 4
) (
   input  dcsw_pkg::frame_ctl_type ctl,
   output dcsw_pkg::frame_res_type res
);

   localparam logic [dcsw_pkg::DEV_W-1:0] CHAIN_W = dcsw_pkg::DEV_W'(CHAIN_LENGTH);
   localparam logic [dcsw_pkg::DEV_W-1:0] LAST_SLOT = CHAIN_W - 3'd1;

   logic [dcsw_pkg::DEV_W-1:0] addr_slot;
   logic                       hit;

   // Devices ahead of the target get no-ops first, so its frame sits at
   // slot CHAIN_LENGTH - device.
   always_comb begin
      addr_slot     = CHAIN_W - ctl.dev;
      hit           = (ctl.slot == addr_slot);
      res.frame     = hit ? {ctl.addr, ctl.data} : '0;
      res.eot       = (ctl.slot == LAST_SLOT);
   end

endmodule
